// ===== rtl/fsa_pkg.sv =====
package fsa_pkg;

	// default sizes
	localparam int PIXELS_DEF     = 65536;
	localparam int MAX_FRAMES_DEF = 4096;

	// field widths
	localparam int OP_W     = 2;
	localparam int IDX_W    = 16;
	localparam int PIX_W    = 12;
	localparam int SUM_W    = 24;
	localparam int VAL_W    = 25;
	localparam int FRAMES_W = 13;
	localparam int CNT_W    = $clog2(SUM_W);
	localparam int IDX_SPAN = 1 << IDX_W;

	// opcodes
	localparam logic [OP_W-1:0] OP_ACC     = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	// register indexes
	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] REG_STACK_MODE   = 2'd1;
	localparam logic [1:0] REG_REDUCE_SUM   = 2'd2;

	// how a read result is formed
	localparam logic [1:0] KIND_ZERO = 2'd0;
	localparam logic [1:0] KIND_RAW  = 2'd1;
	localparam logic [1:0] KIND_DIV  = 2'd2;

	localparam logic [SUM_W-1:0] SUM_MAX = 24'hFF_FFFF;
	localparam logic signed [VAL_W:0] MONO12_OFFSET = 26'sd32768;
	localparam logic signed [VAL_W:0] MONO12_TOP    = 26'sd32767;

endpackage

// ===== rtl/frame_stack_accumulator_core.sv =====
// Per-pixel frame stacker.
// Input words arrive on s_axis_*: tuser carries the opcode and the frame
// dated flag, tdata the pixel index and sample, tlast the last pixel of a
// frame. Accumulates add the sample into a per-pixel sum memory (the first
// frame after a restart overwrites), restarts clear the frame count, reads
// return one word on m_axis_*.
// Accumulates and restarts are taken one per cycle while no read is running:
// the sum memory has one read and one write port, the write-back lands in the
// cycle after the read and a read of the same pixel in that cycle is served
// from the write data. A read holds the input for its whole run: ST_LOAD, then
// ST_DIV only with a division (mean or reduced sum; not for no frames, pixel
// outside the frame, plain sum), then ST_FIN, which raises m_axis_tvalid as it
// returns to taking words. The restoring divider resolves one quotient bit per
// cycle over 24 bits. The result sits in an output register, so further input
// is taken while the receiver stalls; a second read waits at its last step
// until the register frees.
// Reset clears the frame count, the registers and all handshake state; the sum
// memory is not cleared and reads of a pixel never written are meaningless. The
// config channel is always ready; the user must write it only while idle, as the block does not enforce it.
module frame_stack_accumulator_core #(
	parameter int PIXELS     = fsa_pkg::PIXELS_DEF,
	parameter int MAX_FRAMES = fsa_pkg::MAX_FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [0:0]  cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] pixel_index, [27:16] pixel_value, zero pad
	input  logic [2:0]  s_axis_tuser,  // [1:0] opcode, [2] frame_dated
	input  logic        s_axis_tlast,  // last_of_frame
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [24:0] stack_value, [37:25] frames_stacked, zero pad
	output logic        m_axis_tuser   // no_frames
);

	localparam int DEPTH = (PIXELS < fsa_pkg::IDX_SPAN) ? PIXELS : fsa_pkg::IDX_SPAN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FC_W  = $clog2(MAX_FRAMES + 1);
	localparam int SW    = fsa_pkg::SUM_W;

	localparam logic [1:0] ST_RUN  = 2'd0;  // taking words
	localparam logic [1:0] ST_LOAD = 2'd1;  // read data back, set up result
	localparam logic [1:0] ST_DIV  = 2'd2;  // divider iterating
	localparam logic [1:0] ST_FIN  = 2'd3;  // form value, load output

	// config registers
	logic pixel_format_q, stack_mode_q, reduce_sum_q;

	logic [1:0] state_q;
	logic [FC_W-1:0] fc_q;

	// input fields
	logic [fsa_pkg::OP_W-1:0]  in_op;
	logic [fsa_pkg::IDX_W-1:0] in_idx;
	logic [fsa_pkg::PIX_W-1:0] in_pix;
	logic in_dated, in_last, in_acc, idx_ok, room;
	logic [AW-1:0] in_addr;

	// accumulate write-back stage
	logic          acc_s1, ovw_s1, fwd_s1, rd_ok_s1;
	logic [AW-1:0] addr_s1;
	logic [fsa_pkg::PIX_W-1:0] pix_s1;
	logic [SW-1:0] rdata_q, wfwd_q, operand, wdata;
	logic [SW:0]   sum_ext;

	logic [SW-1:0] sum_mem [DEPTH];

	// divider and result
	logic [SW-1:0]   dvd_q;
	logic [FC_W-1:0] rem_q, n_q;
	logic [fsa_pkg::CNT_W-1:0] cnt_q;
	logic [1:0]      kind_q;
	logic [FC_W:0]   trial, two_r;
	logic            qbit, inc;
	logic [fsa_pkg::VAL_W-1:0] v25, value;
	logic signed [fsa_pkg::VAL_W:0] v_off;
	logic            out_free;

	logic [fsa_pkg::VAL_W-1:0]    stack_value_q;
	logic [fsa_pkg::FRAMES_W-1:0] frames_q;
	logic                         no_frames_q, m_valid_q;

	assign in_op    = s_axis_tuser[1:0];
	assign in_dated = s_axis_tuser[2];
	assign in_idx   = s_axis_tdata[15:0];
	assign in_pix   = s_axis_tdata[27:16];
	assign in_last  = s_axis_tlast;
	assign in_addr  = in_idx[AW-1:0];

	assign s_axis_tready = (state_q == ST_RUN);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign idx_ok  = 32'(in_idx) < 32'(PIXELS);
	assign room    = 32'(fc_q) < 32'(MAX_FRAMES);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= 1'b0;
			stack_mode_q   <= 1'b0;
			reduce_sum_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fsa_pkg::REG_PIXEL_FORMAT: pixel_format_q <= cfg_data[0];
				fsa_pkg::REG_STACK_MODE:   stack_mode_q   <= cfg_data[0];
				fsa_pkg::REG_REDUCE_SUM:   reduce_sum_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// read data, or the write landing in the same cycle as the read
	assign operand = fwd_s1 ? wfwd_q : rdata_q;
	assign sum_ext = {1'b0, operand} + (SW+1)'(pix_s1);
	always_comb begin
		if (ovw_s1)
			wdata = SW'(pix_s1);
		else if (sum_ext[SW])
			wdata = fsa_pkg::SUM_MAX;
		else
			wdata = sum_ext[SW-1:0];
	end

	// sum memory: one read, one write per cycle
	always_ff @(posedge clk) begin
		if (acc_s1)
			sum_mem[addr_s1] <= wdata;
		if (in_acc)
			rdata_q <= sum_mem[in_addr];
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1  <= in_addr;
			pix_s1   <= in_pix;
			ovw_s1   <= (fc_q == '0);
			rd_ok_s1 <= idx_ok;
			wfwd_q   <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			fc_q   <= '0;
		end else begin
			acc_s1 <= in_acc && in_op == fsa_pkg::OP_ACC && in_dated && room && idx_ok;
			if (in_acc)
				fwd_s1 <= acc_s1 && addr_s1 == in_addr;
			if (in_acc && in_op == fsa_pkg::OP_ACC && in_dated && room && in_last)
				fc_q <= fc_q + FC_W'(1);
			else if (in_acc && in_op == fsa_pkg::OP_RESTART)
				fc_q <= '0;
		end
	end

	// restoring divider step
	assign trial = {rem_q, dvd_q[SW-1]};
	assign qbit  = trial >= {1'b0, n_q};

	// final rounding: ceil for mono12 mean, truncation for other means, half-even for reduced sum
	assign two_r = {rem_q, 1'b0};
	always_comb begin
		if (!stack_mode_q)
			inc = pixel_format_q && (rem_q != '0);
		else
			inc = (two_r > {1'b0, n_q}) || ((two_r == {1'b0, n_q}) && dvd_q[0]);
		v25   = fsa_pkg::VAL_W'(dvd_q) + fsa_pkg::VAL_W'(inc);
		v_off = $signed({1'b0, v25}) - fsa_pkg::MONO12_OFFSET;
		priority case (1'b1)
			kind_q == fsa_pkg::KIND_ZERO: value = '0;
			kind_q == fsa_pkg::KIND_RAW:  value = fsa_pkg::VAL_W'(dvd_q);
			!pixel_format_q:              value = v25;
			v_off > fsa_pkg::MONO12_TOP:  value = fsa_pkg::VAL_W'(fsa_pkg::MONO12_TOP);
			default:                      value = v_off[fsa_pkg::VAL_W-1:0];
		endcase
	end

	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_RUN: begin
				if (in_acc)
					n_q <= fc_q;
			end
			ST_LOAD: begin
				dvd_q <= operand;
				rem_q <= '0;
				cnt_q <= fsa_pkg::CNT_W'(SW - 1);
				if (n_q == '0 || !rd_ok_s1)
					kind_q <= fsa_pkg::KIND_ZERO;
				else if (stack_mode_q && !reduce_sum_q)
					kind_q <= fsa_pkg::KIND_RAW;
				else
					kind_q <= fsa_pkg::KIND_DIV;
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[SW-2:0], qbit};
				rem_q <= qbit ? trial[FC_W-1:0] - n_q : trial[FC_W-1:0];
				cnt_q <= cnt_q - fsa_pkg::CNT_W'(1);
			end
			default: ;
		endcase
		if (state_q == ST_FIN && out_free) begin
			stack_value_q <= value;
			frames_q      <= fsa_pkg::FRAMES_W'(n_q);
			no_frames_q   <= (n_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RUN:
					if (in_acc && in_op == fsa_pkg::OP_READ)
						state_q <= ST_LOAD;
				ST_LOAD:
					if (n_q == '0 || !rd_ok_s1 || (stack_mode_q && !reduce_sum_q))
						state_q <= ST_FIN;
					else
						state_q <= ST_DIV;
				ST_DIV:
					if (cnt_q == '0)
						state_q <= ST_FIN;
				ST_FIN:
					if (out_free)
						state_q <= ST_RUN;
				default: state_q <= ST_RUN;
			endcase
			if (state_q == ST_FIN && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, frames_q, stack_value_q};
	assign m_axis_tuser  = no_frames_q;

	// frame count stays within the stack depth
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fc_q) <= 32'(MAX_FRAMES))
		else $error("frame count beyond stack depth");

	// an accepted read always enters the result path
	a_read_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_op == fsa_pkg::OP_READ) |=> state_q == ST_LOAD)
		else $error("read not taken into result path");

	// divider finishes after its last step
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> state_q == ST_FIN)
		else $error("divider overran");

	// an empty stack reads as zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[24:0] == '0)
		else $error("empty stack gave a non-zero value");

endmodule

// ===== sim/fsa_stack_checker.sv =====
// Watches the config, input and result channels of the frame stacker,
// keeps its own copy of the sum store and frame count, and checks every
// result word against the oldest predicted one.
module fsa_stack_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [0:0]  cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic [2:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [fsa_pkg::VAL_W-1:0]    value;
		logic [fsa_pkg::FRAMES_W-1:0] frames;
		logic                         empty;
	} pixel_result_t;

	logic [fsa_pkg::SUM_W-1:0]    sums [fsa_pkg::PIXELS_DEF];
	logic [fsa_pkg::FRAMES_W-1:0] frames;
	logic                         mono12;
	logic                         sum_mode;
	logic                         reduce;
	pixel_result_t                stacked_q [$];
	int                           errors = 0;

	assign mismatches = errors;

	function automatic logic [fsa_pkg::VAL_W-1:0] stacked_pixel(
			logic [fsa_pkg::SUM_W-1:0] sum, logic [fsa_pkg::FRAMES_W-1:0] n);
		longint s;
		longint d;
		longint q;
		longint r;
		longint v;
		s = sum;
		d = n;
		if (!sum_mode) begin
			if (!mono12)
				return fsa_pkg::VAL_W'(s / d);
			v = (s + d - 1) / d - longint'(fsa_pkg::MONO12_OFFSET);
		end else if (reduce) begin
			q = s / d;
			r = s % d;
			// round half to even
			if (2 * r > d || (2 * r == d && q[0]))
				q++;
			if (!mono12)
				return fsa_pkg::VAL_W'(q);
			v = q - longint'(fsa_pkg::MONO12_OFFSET);
		end else begin
			return fsa_pkg::VAL_W'(s);
		end
		if (v > longint'(fsa_pkg::MONO12_TOP))
			v = longint'(fsa_pkg::MONO12_TOP);
		return fsa_pkg::VAL_W'(v);
	endfunction

	function automatic void take_word(logic [fsa_pkg::OP_W-1:0] op,
			logic [fsa_pkg::IDX_W-1:0] idx, logic [fsa_pkg::PIX_W-1:0] val,
			logic dated, logic last);
		logic [fsa_pkg::SUM_W:0] total;
		pixel_result_t           res;
		case (op)
			fsa_pkg::OP_ACC: begin
				if (dated && frames < fsa_pkg::MAX_FRAMES_DEF) begin
					if (int'(idx) < fsa_pkg::PIXELS_DEF) begin
						if (frames == 0) begin
							sums[idx] = fsa_pkg::SUM_W'(val);
						end else begin
							total = sums[idx] + val;
							sums[idx] = (total > fsa_pkg::SUM_MAX) ? fsa_pkg::SUM_MAX
								: total[fsa_pkg::SUM_W-1:0];
						end
					end
					if (last)
						frames++;
				end
			end
			fsa_pkg::OP_READ: begin
				res.value  = '0;
				res.frames = frames;
				res.empty  = (frames == 0);
				if (frames != 0 && int'(idx) < fsa_pkg::PIXELS_DEF)
					res.value = stacked_pixel(sums[idx], frames);
				stacked_q.push_back(res);
			end
			fsa_pkg::OP_RESTART: frames = '0;
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_result_t want;
		if (!arst_n) begin
			frames   = '0;
			mono12   = 1'b0;
			sum_mode = 1'b0;
			reduce   = 1'b0;
			stacked_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fsa_pkg::REG_PIXEL_FORMAT: mono12   = cfg_data[0];
					fsa_pkg::REG_STACK_MODE:   sum_mode = cfg_data[0];
					fsa_pkg::REG_REDUCE_SUM:   reduce   = cfg_data[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				take_word(s_axis_tuser[1:0], s_axis_tdata[15:0], s_axis_tdata[27:16],
					s_axis_tuser[2], s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (stacked_q.size() == 0) begin
					$error("result word with nothing expected: tdata %h tuser %b",
						m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					want = stacked_q.pop_front();
					if (m_axis_tdata[24:0] !== want.value) begin
						$error("stack_value: expected %0d, got %0d",
							$signed(want.value), $signed(m_axis_tdata[24:0]));
						errors++;
					end
					if (m_axis_tdata[37:25] !== want.frames) begin
						$error("frames_stacked: expected %0d, got %0d",
							want.frames, m_axis_tdata[37:25]);
						errors++;
					end
					if (m_axis_tuser !== want.empty) begin
						$error("no_frames: expected %0b, got %0b", want.empty, m_axis_tuser);
						errors++;
					end
				end
			end
			outstanding <= stacked_q.size();
		end
	end

endmodule

// ===== sim/frame_stack_accumulator_core_tb.sv =====
// Stimulus and verdict for the frame stacker; the checker beside the block
// does all prediction and comparison.
module frame_stack_accumulator_core_tb;

	// opcode with no meaning, the block drops it
	localparam logic [fsa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	// a division read runs through the whole divider, leave margin for the write-back too
	localparam int DRAIN_CYCLES = 40;
	localparam int POOL_N       = 12;
	localparam int PHASE_ITEMS  = 185;
	localparam int RUN_LIMIT    = 10_000_000;

	typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_STARVED} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [0:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;

	int fails;
	int outstanding;

	// sender-side view of what has been written, so no word ever reads a
	// store entry holding nothing defined
	int                        gen_frames = 0;
	bit                        written [fsa_pkg::PIXELS_DEF];
	logic [fsa_pkg::IDX_W-1:0] written_list [$];
	logic [fsa_pkg::IDX_W-1:0] pool [POOL_N];
	int                        burst_left = 0;

	rx_style_t rx_style = RX_OPEN;
	int        rx_left = 0;

	always #5 clk = ~clk;

	frame_stack_accumulator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	fsa_stack_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (fails),
		.outstanding   (outstanding)
	);

	// Receiver: each spell picks a style and keeps it for a while, from
	// always ready down to long stalls broken by a single ready cycle.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_left       <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_style <= rx_style_t'($urandom_range(0, 2));
				rx_left  <= $urandom_range(20, 300);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_style)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
				default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// One input word; the sender runs in bursts with random gaps between.
	// tvalid is only dropped for a gap or a drain, never between words of a burst.
	task automatic send_word(logic [fsa_pkg::OP_W-1:0] op, logic [fsa_pkg::IDX_W-1:0] idx,
			logic [fsa_pkg::PIX_W-1:0] val, logic dated, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, val, idx};
		s_axis_tuser  <= {dated, op};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (op == fsa_pkg::OP_ACC && dated && gen_frames < fsa_pkg::MAX_FRAMES_DEF) begin
			if (!written[idx]) begin
				written[idx] = 1'b1;
				written_list.push_back(idx);
			end
			if (last)
				gen_frames++;
		end else if (op == fsa_pkg::OP_RESTART) begin
			gen_frames = 0;
		end
	endtask

	// read word; unused fields carry noise
	task automatic read_at(logic [fsa_pkg::IDX_W-1:0] idx);
		send_word(fsa_pkg::OP_READ, idx, 12'($urandom_range(0, 4095)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// read a pixel already written, mostly from the hot pool
	task automatic read_some();
		logic [fsa_pkg::IDX_W-1:0] cand;
		if (written_list.size() == 0)
			return;
		cand = pool[$urandom_range(0, POOL_N - 1)];
		if (!($urandom_range(0, 9) < 6 && written[cand]))
			cand = written_list[$urandom_range(0, written_list.size() - 1)];
		read_at(cand);
	endtask

	task automatic cfg_word(logic [1:0] idx, logic bitval);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= bitval;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_mode(logic mono12, logic sum_mode, logic reduce);
		cfg_word(fsa_pkg::REG_PIXEL_FORMAT, mono12);
		cfg_word(fsa_pkg::REG_STACK_MODE, sum_mode);
		cfg_word(fsa_pkg::REG_REDUCE_SUM, reduce);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and wait for every result plus the block's own tail.
	// The first edge lets the count of the last accepted read settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly whole frames of dated pixels with reads between; some frames
	// hammer one pixel with high samples to push the sums up, a few frames
	// are left without their last pixel, plus restarts and noise. Once a
	// frame is done, adds only go to pixels that already hold a sum.
	task automatic run_phase(int n_items);
		int                        done;
		int                        len;
		logic                      hot;
		logic [fsa_pkg::IDX_W-1:0] hot_idx;
		logic [fsa_pkg::IDX_W-1:0] idx;
		done = 0;
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < POOL_N; i++)
			pool[i] = 16'($urandom_range(0, 65535));
		while (done < n_items) begin
			case ($urandom_range(0, 19))
				0: send_word(OP_UNUSED, 16'($urandom_range(0, 65535)),
					12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				1: send_word(fsa_pkg::OP_ACC, 16'($urandom_range(0, 65535)),
					12'($urandom_range(0, 4095)), 1'b0, 1'($urandom_range(0, 1)));
				2: begin
					send_word(fsa_pkg::OP_RESTART, 16'($urandom_range(0, 65535)),
						12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
					done++;
				end
				default: begin
					len     = $urandom_range(1, 24);
					hot     = ($urandom_range(0, 4) == 0);
					hot_idx = pool[$urandom_range(0, POOL_N - 1)];
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 3) == 0) begin
							read_some();
							done++;
						end
						if (hot)
							idx = hot_idx;
						else if ($urandom_range(0, 7) == 0)
							idx = 16'($urandom_range(0, 65535));
						else
							idx = pool[$urandom_range(0, POOL_N - 1)];
						if (gen_frames != 0 && !written[idx])
							idx = written_list[$urandom_range(0, written_list.size() - 1)];
						send_word(fsa_pkg::OP_ACC, idx,
							hot ? 12'($urandom_range(3500, 4095))
								: 12'($urandom_range(0, 4095)),
							1'b1, (k == len - 1) && ($urandom_range(0, 9) != 0));
						done++;
					end
					read_some();
					done++;
				end
			endcase
		end
	endtask

	initial begin : timeout
		#RUN_LIMIT;
		$display("frame_stack_accumulator_core test failed");
		$finish;
	end

	initial begin : stimulus
		logic [2:0] combo;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_mode(1'b0, 1'b0, 1'b0);

		// directed: extremes, no frames, undated, unused opcode, restart
		send_word(fsa_pkg::OP_ACC, 16'h0000, 12'hFFF, 1'b1, 1'b0);
		send_word(fsa_pkg::OP_ACC, 16'hFFFF, 12'h000, 1'b1, 1'b0);
		read_at(16'h0000);
		send_word(fsa_pkg::OP_ACC, 16'h5555, 12'hAAA, 1'b0, 1'b1);  // undated last pixel
		read_at(16'h0000);
		send_word(OP_UNUSED, 16'hAAAA, 12'h555, 1'b1, 1'b1);
		read_at(16'hFFFF);
		send_word(fsa_pkg::OP_ACC, 16'hAAAA, 12'h555, 1'b1, 1'b1);  // first frame done
		read_at(16'h0000);
		read_at(16'hFFFF);
		read_at(16'hAAAA);
		send_word(fsa_pkg::OP_ACC, 16'h0000, 12'hFFF, 1'b1, 1'b0);
		send_word(fsa_pkg::OP_ACC, 16'hFFFF, 12'h001, 1'b1, 1'b1);
		read_at(16'h0000);
		read_at(16'hFFFF);
		send_word(fsa_pkg::OP_RESTART, 16'h1234, 12'h123, 1'b1, 1'b1);
		read_at(16'h0000);
		send_word(fsa_pkg::OP_ACC, 16'h0000, 12'h007, 1'b1, 1'b1);  // overwrites after restart
		read_at(16'h0000);
		drain();

		// random phases: every setting once, then a couple picked at random
		for (int ph = 0; ph < 10; ph++) begin
			combo = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
			set_mode(combo[0], combo[1], combo[2]);
			run_phase(PHASE_ITEMS);
			drain();
		end

		// the last stack seen through every setting
		for (int c = 0; c < 8; c++) begin
			set_mode(c[0], c[1], c[2]);
			read_at(16'h0000);
			read_some();
			read_some();
			drain();
		end

		if (fails == 0 && outstanding == 0)
			$display("frame_stack_accumulator_core test passed");
		else
			$display("frame_stack_accumulator_core test failed");
		$finish;
	end

endmodule
